### sv/adm_pkg.sv
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types, codes and Q1.15 helpers for the arcade drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package adm_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ECO_SCALE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_TURN_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_FORWARD_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_TURN_FACTOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_INVERT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR_INVERT       = 3'd5;

    // reset values
    localparam logic [15:0]        RST_ECO_SCALE         = 16'd16384;
    localparam logic signed [15:0] RST_ARC_TURN_LEVEL    = -16'sd16384;
    localparam logic signed [15:0] RST_ARC_FORWARD_LEVEL = 16'sd6554;
    localparam logic signed [15:0] RST_ARC_TURN_FACTOR   = 16'sd0;

    // arc angle presets
    localparam logic [8:0]         ARC_ANGLE_FWD   = 9'd90;
    localparam logic [8:0]         ARC_ANGLE_REV   = 9'd270;
    localparam logic signed [15:0] ARC_PRESET_TURN = 16'sd3277;
    localparam logic signed [15:0] ARC_PRESET_FWD  = 16'sd6554;

    localparam logic signed [15:0] Q_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        OP_FWD   = 3'd0,
        OP_TURN  = 3'd1,
        OP_DIG   = 3'd2,
        OP_ARC   = 3'd3,
        OP_TICK  = 3'd4,
        OP_START = 3'd5
    } t_op;

    // digital command: bit 4 clear selects a flag group and an action
    typedef enum logic [1:0] {
        GRP_BRAKE = 2'd0,
        GRP_GEAR  = 2'd1,
        GRP_STRAFE = 2'd2,
        GRP_ECO = 2'd3
    } t_grp;

    typedef enum logic [1:0] {
        ACT_ON     = 2'd0,
        ACT_OFF    = 2'd1,
        ACT_TOGGLE = 2'd2,
        ACT_STATE  = 2'd3
    } t_act;

    localparam logic [4:0] CMD_ARC_MODE = 5'd16;

    typedef struct packed {
        logic [2:0]        op;
        logic [4:0]        digital_command;
        logic              level;
        logic signed [15:0] analog_value;
        logic [8:0]        arc_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] front_left_drive;
        logic signed [15:0] front_right_drive;
        logic signed [15:0] back_left_drive;
        logic signed [15:0] back_right_drive;
        logic              brake_out;
        logic              gear_out;
    } t_out_item;

    // mixed tick values handed to the shaping stage
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic              eco;
        logic              strafe;
        logic              brake;
        logic              brake_out;
        logic              gear_out;
    } t_mix;

    function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = Q_MAX;
        end else if (v < -17'sd32768) begin
            r = Q_MIN;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == Q_MIN) begin
            r = Q_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    // q1.15 product, round half up, saturate
    function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                   input logic signed [16:0] b);
        logic signed [32:0] p;
        logic signed [33:0] s;
        logic signed [15:0] r;
        p = a * b;
        s = ($signed({p[32], p}) + 34'sd16384) >>> 15;
        if (s > 34'sd32767) begin
            r = Q_MAX;
        end else if (s < -34'sd32768) begin
            r = Q_MIN;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/adm_in_if.sv
// ----------------------------------------------------------------------------
// adm_in_if
// Valid/ready channel carrying operator items into the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

interface adm_in_if;
    import adm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/adm_out_if.sv
// ----------------------------------------------------------------------------
// adm_out_if
// Valid/ready channel carrying motor and solenoid commands out of the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

interface adm_out_if;
    import adm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/adm_shaper.sv
// ----------------------------------------------------------------------------
// adm_shaper
// Low power scaling, strafe negation and brake forcing of mixed powers.
// ----------------------------------------------------------------------------
`default_nettype none

module adm_shaper (
    input  adm_pkg::t_mix      i_mix,
    input  logic [15:0]        i_scale,
    output adm_pkg::t_out_item o_item
);
    import adm_pkg::*;

    logic signed [16:0] scale_s;
    logic signed [15:0] left_sc;
    logic signed [15:0] right_sc;
    logic signed [15:0] fl;
    logic signed [15:0] br;

    assign scale_s  = $signed({1'b0, i_scale});
    assign left_sc  = i_mix.eco ? mul_q15(i_mix.left, scale_s) : i_mix.left;
    assign right_sc = i_mix.eco ? mul_q15(i_mix.right, scale_s) : i_mix.right;
    assign fl       = i_mix.strafe ? neg_sat(left_sc) : left_sc;
    assign br       = i_mix.strafe ? neg_sat(right_sc) : right_sc;

    always_comb begin
        o_item.front_left_drive  = i_mix.brake ? 16'sd0 : fl;
        o_item.front_right_drive = i_mix.brake ? 16'sd0 : right_sc;
        o_item.back_left_drive   = i_mix.brake ? 16'sd0 : left_sc;
        o_item.back_right_drive  = i_mix.brake ? 16'sd0 : br;
        o_item.brake_out         = i_mix.brake_out;
        o_item.gear_out          = i_mix.gear_out;
    end

endmodule

`default_nettype wire

### sv/arcade_drive_mixer.sv
// ----------------------------------------------------------------------------
// arcade_drive_mixer
// Arcade drive mixing for a four motor base: operator items update powers
// and flags, a tick item emits four motor commands and two solenoid levels.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    op, digital_command, level, analog_value,
//                                  arc_angle
//  o_out     out  valid / ready    four q1.15 drives, brake_out, gear_out
//  i_cfg_*   in   write enable     register index, 16-bit write data
//
//  one transaction per cycle while o_out is not stalled; a tick result
//  reaches o_out through the input register, mix register and output
//  register, with the add/clamp stage and then the scaling multiplier
//  non-tick transactions update state in the cycle after acceptance, no result
//  synchronous active-low reset clears flags, powers and valids and loads
//  the config defaults
//  a stalled o_out backs up through the mix register; i_in.ready drops only
//  when a tick sits in the input register and every later stage is full
//
`default_nettype none

module arcade_drive_mixer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [adm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [adm_pkg::CFG_W-1:0]     i_cfg_data,
    adm_in_if.sink                        i_in,
    adm_out_if.source                     o_out
);
    import adm_pkg::*;

    // configuration registers
    logic [15:0]        r_eco_scale;
    logic signed [15:0] r_arc_turn_level;
    logic signed [15:0] r_arc_forward_level;
    logic signed [15:0] r_arc_turn_factor;
    logic               r_brake_invert;
    logic               r_gear_invert;
    // arc turn product from the live config
    logic signed [15:0] arc_turn_prod;

    // drive state
    logic signed [15:0] r_forward, n_forward;
    logic signed [15:0] r_turn, n_turn;
    logic               r_brake, n_brake;
    logic               r_gear, n_gear;
    logic               r_strafe, n_strafe;
    logic               r_eco, n_eco;
    logic               r_arc_mode, n_arc_mode;

    // pipeline
    logic      r_v1;
    t_in_item  r_item;
    logic      r_v2;
    t_mix      r_mix, n_mix;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item shaped;

    logic s1_tick;
    logic out_load;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic in_acc;

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign out_load   = !r_out_valid || o_out.ready;
    assign s2_adv     = r_v2 && out_load;
    assign s2_free    = !r_v2 || out_load;
    assign s1_tick    = (r_item.op == OP_TICK);
    // non-tick transactions retire in the input stage
    assign s1_adv     = r_v1 && (!s1_tick || s2_free);
    assign i_in.ready = !r_v1 || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eco_scale         <= RST_ECO_SCALE;
            r_arc_turn_level    <= RST_ARC_TURN_LEVEL;
            r_arc_forward_level <= RST_ARC_FORWARD_LEVEL;
            r_arc_turn_factor   <= RST_ARC_TURN_FACTOR;
            r_brake_invert      <= 1'b0;
            r_gear_invert       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ECO_SCALE:         r_eco_scale         <= i_cfg_data;
                REG_ARC_TURN_LEVEL:    r_arc_turn_level    <= $signed(i_cfg_data);
                REG_ARC_FORWARD_LEVEL: r_arc_forward_level <= $signed(i_cfg_data);
                REG_ARC_TURN_FACTOR:   r_arc_turn_factor   <= $signed(i_cfg_data);
                REG_BRAKE_INVERT:      r_brake_invert      <= i_cfg_data[0];
                REG_GEAR_INVERT:       r_gear_invert       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign arc_turn_prod = mul_q15(r_arc_turn_level,
                                   {r_arc_turn_factor[15], r_arc_turn_factor});

    // ------------------------------------------------------------------
    // state update for the transaction in the input register
    // ------------------------------------------------------------------
    function automatic logic apply_act(input logic cur, input logic [1:0] act,
                                       input logic lvl);
        logic r;
        case (act)
            ACT_ON:     r = lvl ? 1'b1 : cur;
            ACT_OFF:    r = lvl ? 1'b0 : cur;
            ACT_TOGGLE: r = lvl ? !cur : cur;
            default:    r = lvl;
        endcase
        return r;
    endfunction

    always_comb begin
        n_forward   = r_forward;
        n_turn      = r_turn;
        n_brake     = r_brake;
        n_gear      = r_gear;
        n_strafe    = r_strafe;
        n_eco       = r_eco;
        n_arc_mode  = r_arc_mode;
        case (r_item.op)
            OP_FWD: begin
                if (!r_arc_mode) begin
                    n_forward = r_item.analog_value;
                end else if (r_item.analog_value > 16'sd0) begin
                    n_turn    = arc_turn_prod;
                    n_forward = r_arc_forward_level;
                end else if (r_item.analog_value < 16'sd0) begin
                    n_turn    = neg_sat(r_arc_turn_level);
                    n_forward = neg_sat(r_arc_forward_level);
                end else begin
                    n_forward = 16'sd0;
                    n_turn    = 16'sd0;
                end
            end
            OP_TURN: begin
                n_turn = r_arc_mode ? r_arc_turn_level : r_item.analog_value;
            end
            OP_DIG: begin
                if (!r_item.digital_command[4]) begin
                    case (r_item.digital_command[3:2])
                        GRP_BRAKE: n_brake = apply_act(r_brake,
                            r_item.digital_command[1:0], r_item.level);
                        GRP_GEAR: n_gear = apply_act(r_gear,
                            r_item.digital_command[1:0], r_item.level);
                        GRP_STRAFE: n_strafe = apply_act(r_strafe,
                            r_item.digital_command[1:0], r_item.level);
                        default: n_eco = apply_act(r_eco,
                            r_item.digital_command[1:0], r_item.level);
                    endcase
                end else if (r_item.digital_command == CMD_ARC_MODE) begin
                    n_arc_mode = r_item.level;
                    if (!r_item.level) begin
                        n_forward = 16'sd0;
                        n_turn    = 16'sd0;
                    end
                end
            end
            OP_ARC: begin
                if (r_item.arc_angle == ARC_ANGLE_FWD) begin
                    n_turn    = ARC_PRESET_TURN;
                    n_forward = ARC_PRESET_FWD;
                end else if (r_item.arc_angle == ARC_ANGLE_REV) begin
                    n_turn    = ARC_PRESET_TURN;
                    n_forward = -ARC_PRESET_FWD;
                end
            end
            OP_START: begin
                n_forward = 16'sd0;
                n_turn    = 16'sd0;
            end
            default: begin
            end
        endcase
    end

    // mix of the current state for a tick
    always_comb begin
        n_mix.left      = sat17({r_forward[15], r_forward} - {r_turn[15], r_turn});
        n_mix.right     = sat17({r_forward[15], r_forward} + {r_turn[15], r_turn});
        n_mix.eco       = r_eco;
        n_mix.strafe    = r_strafe;
        n_mix.brake     = r_brake;
        n_mix.brake_out = r_brake ^ r_brake_invert;
        n_mix.gear_out  = r_gear ^ r_gear_invert;
    end

    adm_shaper u_shaper (
        .i_mix   (r_mix),
        .i_scale (r_eco_scale),
        .o_item  (shaped)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_forward   <= 16'sd0;
            r_turn      <= 16'sd0;
            r_brake     <= 1'b0;
            r_gear      <= 1'b0;
            r_strafe    <= 1'b0;
            r_eco       <= 1'b0;
            r_arc_mode  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_v1 <= i_in.valid;
            end
            if (s1_adv) begin
                r_forward   <= n_forward;
                r_turn      <= n_turn;
                r_brake     <= n_brake;
                r_gear      <= n_gear;
                r_strafe    <= n_strafe;
                r_eco       <= n_eco;
                r_arc_mode  <= n_arc_mode;
            end
            if (s2_free) begin
                r_v2 <= s1_adv && s1_tick;
            end
            if (out_load) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in.data;
        end
        if (s1_adv && s1_tick) begin
            r_mix <= n_mix;
        end
        if (s2_adv) begin
            r_out_data <= shaped;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_tick_reaches_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_tick) |=> r_v2)
        else $error("tick transaction lost between input and mix stage");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_v1)
        else $error("accepted transaction not held in input register");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && s1_tick && r_v2 && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while pipeline is full");

    a_brake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.brake_out != r_brake_invert)) |->
        (r_out_data.front_left_drive == 16'sd0 && r_out_data.front_right_drive == 16'sd0
         && r_out_data.back_left_drive == 16'sd0 && r_out_data.back_right_drive == 16'sd0))
        else $error("motor command nonzero under brake");

endmodule

`default_nettype wire
